@@ rtl/lsp_pkg.sv @@
// Shared types and constants for the LED sweep / progress driver.
// No dependencies; imported by every module of the block.
package lsp_pkg;

  localparam int unsigned PAT_W        = 8;
  localparam int unsigned POS_W        = 3;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned BYTES_W      = 24;
  localparam int unsigned IVL_W        = 16;
  localparam int unsigned SLOT_BYTES   = 65536;
  localparam int unsigned PROG_W       = 28;

  localparam logic [IVL_W-1:0] IVL_RESET     = 16'd90;
  localparam logic [POS_W-1:0] POS_TOP       = 3'd7;
  localparam logic [POS_W-1:0] POS_BOTTOM    = 3'd0;

  typedef logic [PAT_W-1:0] pat_t;

  localparam pat_t SHOWN_RESET = 8'hff;

  typedef struct packed {
    logic valid;
    pat_t pattern;
  } lsp_push_t;

endpackage

@@ rtl/lsp_front.sv @@
// Front end: accepts polls, keeps sweep state, builds the pad pattern and
// pushes changed patterns to the queue. Depends on lsp_pkg.
module lsp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lsp_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [lsp_pkg::BYTES_W-1:0] in_received_bytes,
  input  logic                        cfg_valid,
  input  logic [lsp_pkg::IVL_W-1:0]   cfg_sweep_interval_ms,
  input  logic                        q_full,
  output lsp_pkg::lsp_push_t          push
);
  import lsp_pkg::*;

  logic [IVL_W-1:0]  interval_r;
  logic [TIME_W-1:0] step_time_r, step_time_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              up_r, up_nxt;
  pat_t              shown_r, shown_nxt;

  logic              accept;
  logic              is_prog;
  logic              step;
  logic [TIME_W-1:0] elapsed;
  logic [PROG_W-1:0] scaled;
  pat_t              bar;
  logic [POS_W-1:0]  pos_step;
  logic              up_step;
  pat_t              pattern;
  logic              emit;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_prog  = (in_received_bytes != '0);
  assign elapsed  = in_now_ms - step_time_r;
  assign step     = !is_prog && (elapsed >= TIME_W'(interval_r));
  assign scaled   = {1'b0, in_received_bytes, 3'b000};

  // progress bar: bit i lit when bytes*8 >= (i+1)*slot
  always_comb begin
    for (int i = 0; i < PAT_W; i++) begin
      bar[i] = (scaled >= PROG_W'((i + 1) * SLOT_BYTES));
    end
  end

  always_comb begin
    pos_step = pos_r;
    up_step  = up_r;
    if (up_r) begin
      if (pos_r == POS_TOP) begin
        up_step  = 1'b0;
        pos_step = POS_TOP - POS_W'(1);
      end else begin
        pos_step = pos_r + POS_W'(1);
      end
    end else begin
      if (pos_r == POS_BOTTOM) begin
        up_step  = 1'b1;
        pos_step = POS_BOTTOM + POS_W'(1);
      end else begin
        pos_step = pos_r - POS_W'(1);
      end
    end
  end

  assign pattern = is_prog ? bar : (pat_t'(1) << pos_step);
  assign emit    = (is_prog || step) && (pattern != shown_r);

  assign push.valid   = accept && emit;
  assign push.pattern = pattern;

  always_comb begin
    step_time_nxt = step_time_r;
    pos_nxt       = pos_r;
    up_nxt        = up_r;
    shown_nxt     = shown_r;
    if (accept && step) begin
      step_time_nxt = in_now_ms;
      pos_nxt       = pos_step;
      up_nxt        = up_step;
    end
    if (push.valid) begin
      shown_nxt = pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= IVL_RESET;
      step_time_r <= '0;
      pos_r       <= POS_BOTTOM;
      up_r        <= 1'b1;
      shown_r     <= SHOWN_RESET;
    end else begin
      if (cfg_valid) begin
        interval_r <= cfg_sweep_interval_ms;
      end
      step_time_r <= step_time_nxt;
      pos_r       <= pos_nxt;
      up_r        <= up_nxt;
      shown_r     <= shown_nxt;
    end
  end

endmodule

@@ rtl/lsp_queue.sv @@
// Two-entry pattern queue between front and back end.
// Depends on lsp_pkg.
module lsp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  lsp_pkg::lsp_push_t push,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output lsp_pkg::pat_t      q_data
);
  import lsp_pkg::*;

  pat_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full    = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.pattern;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

@@ rtl/lsp_back.sv @@
// Back end: serializes one pattern into eight items, MSB first.
// Depends on lsp_pkg.
module lsp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  lsp_pkg::pat_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_pad_bit,
  output logic          out_status_bit,
  output logic          out_last_bit
);
  import lsp_pkg::*;

  pat_t             shift_r;
  logic [POS_W-1:0] cnt_r;
  logic             valid_r;
  logic             take;
  logic             done;

  assign take = valid_r && !out_stall;
  assign done = take && (cnt_r == POS_TOP);
  assign pop  = (!valid_r || done) && q_valid;

  assign out_valid      = valid_r;
  assign out_pad_bit    = shift_r[PAT_W-1];
  assign out_status_bit = 1'b0;
  assign out_last_bit   = (cnt_r == POS_TOP);

  always_ff @(posedge clk) begin
    if (pop) begin
      shift_r <= q_data;
    end else if (take) begin
      shift_r <= {shift_r[PAT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (pop) begin
      valid_r <= 1'b1;
      cnt_r   <= '0;
    end else if (take) begin
      cnt_r <= cnt_r + POS_W'(1);
      if (done) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/led_sweep_progress_driver_unit.sv @@
// LED sweep / progress driver, top level.
// Depends on lsp_pkg, lsp_front, lsp_queue, lsp_back.
//
// Input channel (in_valid / in_stall): one poll per item with the current
// millisecond time and the upload byte count. A nonzero count draws a
// progress bar; a zero count steps a single light back and forth once the
// sweep interval has elapsed. When the pattern changes, the result channel
// (out_valid / out_stall) carries eight items, pattern bit 7 first, with
// out_last_bit set on the eighth; out_status_bit is always 0.
// Configuration (cfg_valid / cfg_ready, always ready) writes the sweep
// interval in ms.
// An accepted changed pattern is registered in the queue, then loaded into
// the serializer register that drives the first bit. Throughput: a poll is
// taken every cycle while the two-entry pattern queue has room; a pattern
// holds the serializer for its eight items, which paces changing patterns.
// Reset (synchronous, active low): interval 90, sweep at 0 moving up, shown
// pattern 0xff, queue and serializer empty.
// When the receiver stalls, the current bit holds; the queue fills and then
// in_stall rises until the serializer moves on.
module led_sweep_progress_driver_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lsp_pkg::TIME_W-1:0]  in_now_ms,
  input  logic [lsp_pkg::BYTES_W-1:0] in_received_bytes,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_pad_bit,
  output logic                        out_status_bit,
  output logic                        out_last_bit,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lsp_pkg::IVL_W-1:0]   cfg_sweep_interval_ms
);
  import lsp_pkg::*;

  lsp_push_t push;
  logic      q_full;
  logic      q_valid;
  pat_t      q_data;
  logic      pop;

  assign cfg_ready = 1'b1;

  lsp_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_now_ms             (in_now_ms),
    .in_received_bytes     (in_received_bytes),
    .cfg_valid             (cfg_valid && cfg_ready),
    .cfg_sweep_interval_ms (cfg_sweep_interval_ms),
    .q_full                (q_full),
    .push                  (push)
  );

  lsp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_data  (q_data)
  );

  lsp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pad_bit    (out_pad_bit),
    .out_status_bit (out_status_bit),
    .out_last_bit   (out_last_bit)
  );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for led_sweep_progress_driver_unit: directed polls, then random
// polls in four flow-control phases, each result bit checked against an in-bench predictor.
// Depends on lsp_pkg and the RTL of led_sweep_progress_driver_unit.
`timescale 1ns / 100ps

module tb;
  import lsp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    ROW_POLL_ANY,
    ROW_POLL_NONE,
    ROW_POLL_SHOWS,
    ROW_CFG
  } row_e;

  typedef struct packed {
    row_e               kind;
    logic [TIME_W-1:0]  now;
    logic [BYTES_W-1:0] bytes;
    pat_t               pads;
    logic [IVL_W-1:0]   ivl;
  } dir_row_t;

  typedef struct packed {
    logic pad;
    logic status;
    logic last;
  } led_bit_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [TIME_W-1:0]   in_now_ms;
  logic [BYTES_W-1:0]  in_received_bytes;
  logic                out_valid;
  logic                out_stall;
  logic                out_pad_bit;
  logic                out_status_bit;
  logic                out_last_bit;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IVL_W-1:0]    cfg_sweep_interval_ms;

  // predictor state
  logic [IVL_W-1:0]    interval_ms;
  logic [TIME_W-1:0]   last_step_ms;
  logic [POS_W-1:0]    sweep_at;
  logic                sweep_rising;
  pat_t                pads_shown;

  led_bit_t            bits_due[$];
  int                  errors;
  int                  cycles;
  int                  idle_pct;
  int                  stall_pct;
  logic [TIME_W-1:0]   ms_clock;
  int                  upload_bytes;
  dir_row_t            dir_rows[25];

  led_sweep_progress_driver_unit u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_now_ms             (in_now_ms),
    .in_received_bytes     (in_received_bytes),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_pad_bit           (out_pad_bit),
    .out_status_bit        (out_status_bit),
    .out_last_bit          (out_last_bit),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_sweep_interval_ms (cfg_sweep_interval_ms)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    led_bit_t exp_bit;
    if (rst_n && out_valid && !out_stall) begin
      if (bits_due.size() == 0) begin
        $error("unexpected item: pad_bit %0b last_bit %0b", out_pad_bit, out_last_bit);
        errors++;
      end else begin
        exp_bit = bits_due.pop_front();
        if (out_pad_bit !== exp_bit.pad) begin
          $error("pad_bit: expected %0b, got %0b", exp_bit.pad, out_pad_bit);
          errors++;
        end
        if (out_status_bit !== exp_bit.status) begin
          $error("status_bit: expected %0b, got %0b", exp_bit.status, out_status_bit);
          errors++;
        end
        if (out_last_bit !== exp_bit.last) begin
          $error("last_bit: expected %0b, got %0b", exp_bit.last, out_last_bit);
          errors++;
        end
      end
    end
  end

  // Returns 1 when the poll changes the pads; pads then holds the new pattern.
  function automatic logic next_pads(input logic [TIME_W-1:0] now,
                                     input logic [BYTES_W-1:0] bytes,
                                     output pat_t pads);
    logic [31:0] lit;
    pads = '0;
    if (bytes != 0) begin
      lit = ({8'b0, bytes} * 32'd8) / SLOT_BYTES;
      pads = (lit >= 8) ? 8'hff : pat_t'((32'd1 << lit) - 32'd1);
    end else begin
      if (now - last_step_ms < {16'b0, interval_ms}) return 1'b0;
      last_step_ms = now;
      if (sweep_rising) begin
        if (sweep_at == POS_TOP) begin
          sweep_rising = 1'b0;
          sweep_at = POS_TOP - 3'd1;
        end else begin
          sweep_at = sweep_at + 3'd1;
        end
      end else if (sweep_at == POS_BOTTOM) begin
        sweep_rising = 1'b1;
        sweep_at = POS_BOTTOM + 3'd1;
      end else begin
        sweep_at = sweep_at - 3'd1;
      end
      pads = pat_t'(1) << sweep_at;
    end
    if (pads == pads_shown) return 1'b0;
    pads_shown = pads;
    return 1'b1;
  endfunction

  task automatic send_poll(input logic [TIME_W-1:0] now, input logic [BYTES_W-1:0] bytes,
                           input row_e kind, input pat_t typed);
    pat_t pads;
    logic shows;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_now_ms <= now;
    in_received_bytes <= bytes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shows = next_pads(now, bytes, pads);
    if (kind == ROW_POLL_NONE && shows) begin
      $error("pattern: expected no write, got %h", pads);
      errors++;
    end
    if (kind == ROW_POLL_SHOWS && (!shows || pads != typed)) begin
      $error("pattern: expected %h, got %h (write %0b)", typed, pads, shows);
      errors++;
    end
    if (shows) begin
      for (int k = 0; k < 8; k++) begin
        bits_due.push_back('{pad: pads[7-k], status: 1'b0, last: (k == 7)});
      end
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (bits_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_interval(input logic [IVL_W-1:0] ivl);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_sweep_interval_ms <= ivl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    interval_ms = ivl;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n, input logic hold_mid);
    logic [TIME_W-1:0] now;
    logic [BYTES_W-1:0] bytes;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) begin
        wait_drained();
        @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        ms_clock += $urandom_range(0, 32'(interval_ms) * 3 / 2 + 1);
        bytes = '0;
      end else if (pick < 80) begin
        upload_bytes += $urandom_range(0, 12000);
        ms_clock += $urandom_range(0, 50);
        if (upload_bytes > 70000) upload_bytes = 0;
        bytes = BYTES_W'(upload_bytes);
      end else if (pick < 90) begin
        ms_clock += $urandom_range(0, 3);
        bytes = BYTES_W'($urandom_range(0, 24'hffffff));
      end else begin
        ms_clock = $urandom;
        bytes = $urandom_range(0, 1) ? BYTES_W'($urandom) : '0;
      end
      now = ms_clock;
      send_poll(now, bytes, ROW_POLL_ANY, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_now_ms = '0;
    in_received_bytes = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_sweep_interval_ms = '0;
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    ms_clock = '0;
    upload_bytes = 0;
    interval_ms = IVL_RESET;
    last_step_ms = '0;
    sweep_at = POS_BOTTOM;
    sweep_rising = 1'b1;
    pads_shown = SHOWN_RESET;

    dir_rows = '{
      '{ROW_POLL_NONE,  32'd0,        24'd0,        8'h00, 16'd0},
      '{ROW_POLL_SHOWS, 32'd90,       24'd0,        8'h02, 16'd0},
      '{ROW_POLL_SHOWS, 32'd0,        24'hffffff,   8'hff, 16'd0},
      '{ROW_POLL_SHOWS, 32'd0,        24'd1,        8'h00, 16'd0},
      '{ROW_POLL_SHOWS, 32'd0,        24'd8192,     8'h01, 16'd0},
      '{ROW_POLL_SHOWS, 32'd0,        24'd57344,    8'h7f, 16'd0},
      '{ROW_POLL_NONE,  32'd0,        24'd65535,    8'h00, 16'd0},
      '{ROW_POLL_SHOWS, 32'd0,        24'd65536,    8'hff, 16'd0},
      '{ROW_POLL_SHOWS, 32'hffffffff, 24'd0,        8'h04, 16'd0},
      '{ROW_POLL_NONE,  32'd88,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_SHOWS, 32'd89,       24'd0,        8'h08, 16'd0},
      '{ROW_CFG,        32'd0,        24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_POLL_ANY,   32'd89,       24'd0,        8'h00, 16'd0},
      '{ROW_CFG,        32'd0,        24'd0,        8'h00, 16'hffff}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset state, progress extremes, wrap of the ms counter, both sweep turns
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_interval(dir_rows[i].ivl);
      end else begin
        send_poll(dir_rows[i].now, dir_rows[i].bytes, dir_rows[i].kind, dir_rows[i].pads);
      end
    end
    ms_clock = 32'd89;

    write_interval(16'd1);
    idle_pct = 0;
    stall_pct = 0;
    run_random(97, 1'b0);

    write_interval(IVL_W'($urandom_range(0, 65535)));
    idle_pct = 78;
    stall_pct = 0;
    run_random(97, 1'b1);

    write_interval(16'hffff);
    idle_pct = 0;
    stall_pct = 78;
    run_random(97, 1'b0);

    write_interval(IVL_W'($urandom_range(20, 400)));
    idle_pct = 27;
    stall_pct = 27;
    run_random(97, 1'b0);

    wait_drained();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
